// ----- sv/rxu_pkg.sv -----
// Shared types and constants for the RISC execute unit.
// Opcode and register constants, status codes and the execute result record.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rxu_pkg;

   // Machine geometry
   localparam int unsigned XLEN                = 32;
   localparam int unsigned PC_W                = 16;
   localparam int unsigned NUM_REGS            = 16;
   localparam int unsigned REG_IDX_W           = 4;
   localparam int unsigned OPCODE_W            = 5;
   localparam int unsigned IMM_W               = 12;
   localparam int unsigned PRELOAD_ADDR_W      = 12;
   localparam int unsigned STORE_DEPTH_DEFAULT = 4096;

   // Item kinds
   localparam logic KIND_EXEC    = 1'b0;
   localparam logic KIND_PRELOAD = 1'b1;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_ADD  = 5'd0;
   localparam logic [OPCODE_W-1:0] OP_SUB  = 5'd1;
   localparam logic [OPCODE_W-1:0] OP_AND  = 5'd2;
   localparam logic [OPCODE_W-1:0] OP_OR   = 5'd3;
   localparam logic [OPCODE_W-1:0] OP_SLL  = 5'd4;
   localparam logic [OPCODE_W-1:0] OP_SRA  = 5'd5;
   localparam logic [OPCODE_W-1:0] OP_SRL  = 5'd6;
   localparam logic [OPCODE_W-1:0] OP_BEQ  = 5'd7;
   localparam logic [OPCODE_W-1:0] OP_BNE  = 5'd8;
   localparam logic [OPCODE_W-1:0] OP_BLT  = 5'd9;
   localparam logic [OPCODE_W-1:0] OP_BGT  = 5'd10;
   localparam logic [OPCODE_W-1:0] OP_BLE  = 5'd11;
   localparam logic [OPCODE_W-1:0] OP_BGE  = 5'd12;
   localparam logic [OPCODE_W-1:0] OP_JAL  = 5'd13;
   localparam logic [OPCODE_W-1:0] OP_LW   = 5'd14;
   localparam logic [OPCODE_W-1:0] OP_SW   = 5'd15;
   localparam logic [OPCODE_W-1:0] OP_HALT = 5'd19;

   // Architectural registers with a fixed role
   localparam logic [REG_IDX_W-1:0] REG_ZERO = 4'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMM  = 4'd1;
   localparam logic [REG_IDX_W-1:0] REG_LINK = 4'd15;

   typedef enum logic [1:0] {
      STATUS_DONE        = 2'd0,
      STATUS_HALTED      = 2'd1,
      STATUS_UNSUPPORTED = 2'd2
   } status_type;

   // Outcome of the execute stage for one beat
   typedef struct packed {
      logic [PC_W-1:0]      next_pc;
      logic                 pc_update;
      status_type           status;
      logic                 dest_written;
      logic [REG_IDX_W-1:0] dest_index;
      logic [XLEN-1:0]      dest_value;
      logic                 is_load;
      logic                 store_en;
      logic [XLEN-1:0]      store_data;
      logic [XLEN-1:0]      mem_addr;
   } exec_result_type;

   // Register file write port
   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] index;
      logic [XLEN-1:0]      data;
   } rf_write_type;

endpackage

`default_nettype wire

// ----- sv/rxu_regfile.sv -----
// Register file of the RISC execute unit: two synchronous-read copies, valid bits
// and per-port bypass so that held operands track writes that land after the read.
// Depends on rxu_pkg.
`default_nettype none

module rxu_regfile (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      load,
   input  wire logic [2:0][rxu_pkg::REG_IDX_W-1:0]        load_idx,
   input  wire logic [2:0][rxu_pkg::REG_IDX_W-1:0]        cur_idx,
   input  wire rxu_pkg::rf_write_type                     wr,
   output logic      [2:0][rxu_pkg::XLEN-1:0]             rd_value
);
   import rxu_pkg::*;

   // Bank 0 serves ports 0 and 1, bank 1 serves port 2
   logic [XLEN-1:0]     bank0 [NUM_REGS];
   logic [XLEN-1:0]     bank1 [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;

   // Writes go to both copies; an entry reads as zero until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.index] <= 1'b1;
      end
      if (wr.en) begin
         bank0[wr.index] <= wr.data;
         bank1[wr.index] <= wr.data;
      end
   end

   for (genvar p = 0; p < 3; p++) begin : g_port
      logic [XLEN-1:0]      raw_ff;
      logic                 vld_ff;
      logic                 patch_ff;
      logic                 patch_in;
      logic [XLEN-1:0]      patch_val_ff;
      logic [XLEN-1:0]      patch_val_in;
      logic [REG_IDX_W-1:0] watch_idx;

      if (p < 2) begin : g_bank0
         always_ff @(posedge clock) begin
            if (load) begin
               raw_ff <= bank0[load_idx[p]];
            end
         end
      end else begin : g_bank1
         always_ff @(posedge clock) begin
            if (load) begin
               raw_ff <= bank1[load_idx[p]];
            end
         end
      end

      // A write landing at the read edge, or while the operand is held,
      // is missed by the array read: keep it in the patch register
      assign watch_idx = load ? load_idx[p] : cur_idx[p];

      always_comb begin
         patch_in     = patch_ff & ~load;
         patch_val_in = patch_val_ff;
         if (wr.en && (wr.index == watch_idx)) begin
            patch_in     = 1'b1;
            patch_val_in = wr.data;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            patch_ff <= 1'b0;
            vld_ff   <= 1'b0;
         end else begin
            patch_ff <= patch_in;
            if (load) begin
               vld_ff <= valid_ff[load_idx[p]];
            end
         end
         patch_val_ff <= patch_val_in;
      end

      // Newest first: write in flight, patched value, array, reset zero
      always_comb begin
         if (wr.en && (wr.index == cur_idx[p])) begin
            rd_value[p] = wr.data;
         end else if (patch_ff) begin
            rd_value[p] = patch_val_ff;
         end else if (vld_ff) begin
            rd_value[p] = raw_ff;
         end else begin
            rd_value[p] = '0;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/rxu_alu.sv -----
// Execute logic of the RISC execute unit: ALU, shifter, branch compare,
// next pc and load/store address for one beat. Depends on rxu_pkg.
`default_nettype none

module rxu_alu (
   input  wire logic                                  kind,
   input  wire logic [rxu_pkg::OPCODE_W-1:0]          opcode,
   input  wire logic [rxu_pkg::REG_IDX_W-1:0]         dest_reg,
   input  wire logic [rxu_pkg::PC_W-1:0]              pc,
   input  wire logic [rxu_pkg::XLEN-1:0]              op_a,
   input  wire logic [rxu_pkg::XLEN-1:0]              op_b,
   input  wire logic [rxu_pkg::XLEN-1:0]              op_d,
   input  wire logic [rxu_pkg::PRELOAD_ADDR_W-1:0]    preload_address,
   input  wire logic [rxu_pkg::XLEN-1:0]              preload_data,
   output rxu_pkg::exec_result_type                   result
);
   import rxu_pkg::*;

   logic [PC_W-1:0] pc_plus1;
   logic [4:0]      shamt;
   logic [XLEN-1:0] sum;
   logic            taken;

   assign pc_plus1 = pc + PC_W'(1);
   assign shamt    = op_b[4:0];
   assign sum      = op_a + op_b;

   // Signed branch conditions
   always_comb begin
      case (opcode)
         OP_BEQ:  taken = (op_a == op_b);
         OP_BNE:  taken = (op_a != op_b);
         OP_BLT:  taken = ($signed(op_a) <  $signed(op_b));
         OP_BGT:  taken = ($signed(op_a) >  $signed(op_b));
         OP_BLE:  taken = ($signed(op_a) <= $signed(op_b));
         default: taken = ($signed(op_a) >= $signed(op_b));
      endcase
   end

   always_comb begin
      result            = '0;
      result.next_pc    = pc;
      result.status     = STATUS_DONE;
      result.mem_addr   = sum;
      result.store_data = op_d;

      if (kind == KIND_PRELOAD) begin
         // preload: data store write only, pc held
         result.store_en   = 1'b1;
         result.store_data = preload_data;
         result.mem_addr   = XLEN'(preload_address);
      end else begin
         result.pc_update = 1'b1;
         unique case (opcode) inside
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLL, OP_SRA, OP_SRL: begin
               result.dest_written = 1'b1;
               result.dest_index   = dest_reg;
               result.next_pc      = pc_plus1;
               case (opcode)
                  OP_ADD:  result.dest_value = sum;
                  OP_SUB:  result.dest_value = op_a - op_b;
                  OP_AND:  result.dest_value = op_a & op_b;
                  OP_OR:   result.dest_value = op_a | op_b;
                  OP_SLL:  result.dest_value = op_a << shamt;
                  OP_SRA:  result.dest_value = XLEN'($signed(op_a) >>> shamt);
                  default: result.dest_value = op_a >> shamt;
               endcase
            end
            OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE: begin
               result.next_pc = taken ? op_d[PC_W-1:0] : pc_plus1;
            end
            OP_JAL: begin
               // link is written before the target is read
               result.dest_written = 1'b1;
               result.dest_index   = REG_LINK;
               result.dest_value   = XLEN'(pc_plus1);
               result.next_pc      = (dest_reg == REG_LINK) ? pc_plus1 : op_d[PC_W-1:0];
            end
            OP_LW: begin
               result.dest_written = 1'b1;
               result.dest_index   = dest_reg;
               result.is_load      = 1'b1;
               result.next_pc      = pc_plus1;
            end
            OP_SW: begin
               result.store_en = 1'b1;
               result.next_pc  = pc_plus1;
            end
            OP_HALT: begin
               result.status = STATUS_HALTED;
            end
            default: begin
               result.status = STATUS_UNSUPPORTED;
            end
         endcase

         // register zero drops its write
         if (result.dest_written && (result.dest_index == REG_ZERO)) begin
            result.dest_written = 1'b0;
            result.dest_value   = '0;
            result.is_load      = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/risc_execute_unit_top.sv -----
// Execute stage of a 16-register, 32-bit machine: the top level of the block.
// Instantiates rxu_regfile and rxu_alu; depends on rxu_pkg.
//
// Usage
//   req_* carries one beat: a decoded instruction (req_kind = 0) or a data
//   store preload (req_kind = 1). A beat is taken at a rising edge with
//   req_valid high and req_stall low. rsp_* returns exactly one result per
//   request beat, in order, taken when rsp_valid is high and rsp_stall low.
//   Throughput: one beat per cycle while rsp_stall is low, back to back,
//   including dependent instructions and loads; operands are bypassed
//   from the write-back port.
//   Pipeline: register file read (synchronous, two copies for three read
//   ports), execute with data store access, then the output register, from
//   which register writes are retired in the first cycle that it holds a result.
//   While rsp_stall holds a result, one further beat is taken into the
//   execute stage; req_stall rises only when both stages are full.
//   Reset clears the pc, the register file (valid bits) and both stages.
//   The data store has no reset: words must be written before they are read.
//   STORE_DEPTH must be a power of two; addresses wrap to its width.
`default_nettype none

module risc_execute_unit_top #(
   parameter int unsigned STORE_DEPTH = rxu_pkg::STORE_DEPTH_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic                                      req_kind,
   input  wire logic        [rxu_pkg::OPCODE_W-1:0]       req_opcode,
   input  wire logic        [rxu_pkg::REG_IDX_W-1:0]      req_dest_reg,
   input  wire logic        [rxu_pkg::REG_IDX_W-1:0]      req_src_a_reg,
   input  wire logic        [rxu_pkg::REG_IDX_W-1:0]      req_src_b_reg,
   input  wire logic signed [rxu_pkg::IMM_W-1:0]          req_immediate,
   input  wire logic        [rxu_pkg::PRELOAD_ADDR_W-1:0] req_preload_address,
   input  wire logic signed [rxu_pkg::XLEN-1:0]           req_preload_data,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic             [rxu_pkg::PC_W-1:0]           rsp_next_pc,
   output logic             [1:0]                         rsp_status,
   output logic                                           rsp_dest_written,
   output logic             [rxu_pkg::REG_IDX_W-1:0]      rsp_dest_index,
   output logic signed      [rxu_pkg::XLEN-1:0]           rsp_dest_value
);
   import rxu_pkg::*;

   localparam int unsigned STORE_AW = $clog2(STORE_DEPTH);

   // Handshake
   logic req_accept;
   logic out_free;
   logic ex_adv;

   // Execute stage
   logic                        ex_valid_ff, ex_valid_in;
   logic                        ex_kind_ff;
   logic [OPCODE_W-1:0]         ex_opcode_ff;
   logic [REG_IDX_W-1:0]        ex_dest_ff;
   logic [REG_IDX_W-1:0]        ex_src_a_ff;
   logic [REG_IDX_W-1:0]        ex_src_b_ff;
   logic signed [IMM_W-1:0]     ex_imm_ff;
   logic [PRELOAD_ADDR_W-1:0]   ex_paddr_ff;
   logic [XLEN-1:0]             ex_pdata_ff;
   logic [PC_W-1:0]             pc_ff, pc_in;

   // Operands
   logic [2:0][REG_IDX_W-1:0]   rf_load_idx;
   logic [2:0][REG_IDX_W-1:0]   rf_cur_idx;
   logic [2:0][XLEN-1:0]        rf_value;
   logic [XLEN-1:0]             imm_ext;
   logic [XLEN-1:0]             op_a, op_b, op_d;
   exec_result_type             ex_result;
   rf_write_type                rf_wr;

   // Data store
   logic [XLEN-1:0]             store_mem [STORE_DEPTH];
   logic [STORE_AW-1:0]         store_addr;
   logic [XLEN-1:0]             ld_data_ff;

   // Output register
   logic                        out_valid_ff, out_valid_in;
   logic                        fresh_ff;
   logic [PC_W-1:0]             out_next_pc_ff;
   status_type                  out_status_ff;
   logic                        out_written_ff;
   logic [REG_IDX_W-1:0]        out_index_ff;
   logic [XLEN-1:0]             out_value_ff;
   logic                        out_load_ff;
   logic [XLEN-1:0]             wb_value;

   // Flow control: the execute stage moves when the output register frees
   assign out_free   = ~out_valid_ff | ~rsp_stall;
   assign ex_adv     = ex_valid_ff & out_free;
   assign req_stall  = ex_valid_ff & ~out_free;
   assign req_accept = req_valid & ~req_stall;

   assign ex_valid_in  = req_accept | (ex_valid_ff & ~ex_adv);
   assign out_valid_in = ex_adv | (out_valid_ff & rsp_stall);
   assign pc_in        = (ex_adv && ex_result.pc_update) ? ex_result.next_pc : pc_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fresh_ff     <= 1'b0;
         pc_ff        <= '0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
         fresh_ff     <= ex_adv;
         pc_ff        <= pc_in;
      end
   end

   // Execute stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ex_kind_ff   <= req_kind;
         ex_opcode_ff <= req_opcode;
         ex_dest_ff   <= req_dest_reg;
         ex_src_a_ff  <= req_src_a_reg;
         ex_src_b_ff  <= req_src_b_reg;
         ex_imm_ff    <= req_immediate;
         ex_paddr_ff  <= req_preload_address;
         ex_pdata_ff  <= req_preload_data;
      end
   end

   // Register file: port 0 rs, port 1 rt, port 2 rd
   assign rf_load_idx[0] = req_src_a_reg;
   assign rf_load_idx[1] = req_src_b_reg;
   assign rf_load_idx[2] = req_dest_reg;
   assign rf_cur_idx[0]  = ex_src_a_ff;
   assign rf_cur_idx[1]  = ex_src_b_ff;
   assign rf_cur_idx[2]  = ex_dest_ff;

   // Retire the register write in the first cycle of the output register
   assign wb_value    = out_load_ff ? ld_data_ff : out_value_ff;
   assign rf_wr.en    = fresh_ff & out_written_ff;
   assign rf_wr.index = out_index_ff;
   assign rf_wr.data  = wb_value;

   rxu_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept),
      .load_idx (rf_load_idx),
      .cur_idx  (rf_cur_idx),
      .wr       (rf_wr),
      .rd_value (rf_value)
   );

   // Register 1 always holds this beat's immediate
   assign imm_ext = XLEN'(ex_imm_ff);
   assign op_a    = (ex_src_a_ff == REG_IMM) ? imm_ext : rf_value[0];
   assign op_b    = (ex_src_b_ff == REG_IMM) ? imm_ext : rf_value[1];
   assign op_d    = (ex_dest_ff  == REG_IMM) ? imm_ext : rf_value[2];

   rxu_alu u_alu (
      .kind            (ex_kind_ff),
      .opcode          (ex_opcode_ff),
      .dest_reg        (ex_dest_ff),
      .pc              (pc_ff),
      .op_a            (op_a),
      .op_b            (op_b),
      .op_d            (op_d),
      .preload_address (ex_paddr_ff),
      .preload_data    (ex_pdata_ff),
      .result          (ex_result)
   );

   // Data store: one write and one registered read per beat
   assign store_addr = ex_result.mem_addr[STORE_AW-1:0];

   always_ff @(posedge clock) begin
      if (ex_adv && ex_result.store_en) begin
         store_mem[store_addr] <= ex_result.store_data;
      end
      if (ex_adv) begin
         ld_data_ff <= store_mem[store_addr];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (ex_adv) begin
         out_next_pc_ff <= ex_result.next_pc;
         out_status_ff  <= ex_result.status;
         out_written_ff <= ex_result.dest_written;
         out_index_ff   <= ex_result.dest_index;
         out_value_ff   <= ex_result.dest_value;
         out_load_ff    <= ex_result.is_load;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_next_pc      = out_next_pc_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_dest_written = out_written_ff;
   assign rsp_dest_index   = out_index_ff;
   assign rsp_dest_value   = wb_value;

endmodule

`default_nettype wire

// ----- sv/rxu_checker.sv -----
// Port-level checks for the RISC execute unit, bound to risc_execute_unit_top.
// Depends on rxu_pkg.
`default_nettype none

module rxu_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire logic [rxu_pkg::PC_W-1:0]              rsp_next_pc,
   input  wire logic [1:0]                            rsp_status,
   input  wire logic                                  rsp_dest_written,
   input  wire logic [rxu_pkg::REG_IDX_W-1:0]         rsp_dest_index,
   input  wire logic [rxu_pkg::XLEN-1:0]              rsp_dest_value
);
   import rxu_pkg::*;

   // No result beat straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat offered after reset");

   // A register write is only reported by an executed step, never to register zero
   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_written |->
         rsp_dest_index != REG_ZERO && rsp_status == STATUS_DONE)
      else $error("bad register write report");

   // Without a write the destination fields are zero
   a_nowrite_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dest_written |->
         rsp_dest_index == REG_ZERO && rsp_dest_value == '0)
      else $error("destination fields set without a write");

   // A stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_next_pc) && $stable(rsp_status) &&
         $stable(rsp_dest_written) && $stable(rsp_dest_index) &&
         $stable(rsp_dest_value))
      else $error("stalled result beat changed");

endmodule

bind risc_execute_unit_top rxu_checker u_rxu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_next_pc      (rsp_next_pc),
   .rsp_status       (rsp_status),
   .rsp_dest_written (rsp_dest_written),
   .rsp_dest_index   (rsp_dest_index),
   .rsp_dest_value   (rsp_dest_value)
);

`default_nettype wire

// ----- sim/rxu_exec_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the RISC execute unit: watches both channels, predicts each result beat
// from its own copy of the machine state and compares it field by field.
// Depends on rxu_pkg; instantiated by tb_risc_execute_unit_top beside the block.
module rxu_exec_checker #(
   parameter int unsigned STORE_DEPTH = rxu_pkg::STORE_DEPTH_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   input  wire logic                                      req_stall,
   input  wire logic                                      req_kind,
   input  wire logic        [rxu_pkg::OPCODE_W-1:0]       req_opcode,
   input  wire logic        [rxu_pkg::REG_IDX_W-1:0]      req_dest_reg,
   input  wire logic        [rxu_pkg::REG_IDX_W-1:0]      req_src_a_reg,
   input  wire logic        [rxu_pkg::REG_IDX_W-1:0]      req_src_b_reg,
   input  wire logic signed [rxu_pkg::IMM_W-1:0]          req_immediate,
   input  wire logic        [rxu_pkg::PRELOAD_ADDR_W-1:0] req_preload_address,
   input  wire logic signed [rxu_pkg::XLEN-1:0]           req_preload_data,
   input  wire logic                                      rsp_valid,
   input  wire logic                                      rsp_stall,
   input  wire logic        [rxu_pkg::PC_W-1:0]           rsp_next_pc,
   input  wire logic        [1:0]                         rsp_status,
   input  wire logic                                      rsp_dest_written,
   input  wire logic        [rxu_pkg::REG_IDX_W-1:0]      rsp_dest_index,
   input  wire logic signed [rxu_pkg::XLEN-1:0]           rsp_dest_value,
   output int unsigned                                    fail_count,
   output int unsigned                                    pending_beats,
   output int unsigned                                    exec_beats,
   output int unsigned                                    preload_beats,
   output int unsigned                                    checked_results,
   output int unsigned                                    opcodes_seen
);
   import rxu_pkg::*;

   localparam int unsigned REPORT_CAP = 40;
   localparam int unsigned SAW        = $clog2(STORE_DEPTH);

   typedef struct packed {
      logic [PC_W-1:0]      next_pc;
      status_type           status;
      logic                 written;
      logic [REG_IDX_W-1:0] index;
      logic [XLEN-1:0]      value;
   } step_outcome_type;

   // Shadow machine state
   logic [XLEN-1:0]      arch_regs [NUM_REGS];
   logic [PC_W-1:0]      arch_pc;
   logic [XLEN-1:0]      shadow_store [STORE_DEPTH];
   logic [31:0]          op_seen;
   step_outcome_type     outcome_q [$];

   assign pending_beats = outcome_q.size();
   assign opcodes_seen  = $countones(op_seen);

   // One line per mismatch, capped so a broken block cannot flood the log
   task automatic report_mismatch(input string field, input logic [XLEN-1:0] got,
                                  input logic [XLEN-1:0] want);
      if (fail_count < REPORT_CAP)
         $display("%0t rxu mismatch on %s: got 0x%08h, expected 0x%08h",
                  $time, field, got, want);
      fail_count++;
   endtask

   function automatic logic branch_taken(input logic [OPCODE_W-1:0] op,
                                         input logic [XLEN-1:0] a, input logic [XLEN-1:0] b);
      case (op)
         OP_BEQ:  return a == b;
         OP_BNE:  return a != b;
         OP_BLT:  return $signed(a) <  $signed(b);
         OP_BGT:  return $signed(a) >  $signed(b);
         OP_BLE:  return $signed(a) <= $signed(b);
         default: return $signed(a) >= $signed(b);
      endcase
   endfunction

   // Advance the shadow machine by one beat and give the result it must produce
   task automatic execute_step(input logic kind, input logic [OPCODE_W-1:0] op,
                               input logic [REG_IDX_W-1:0] rd, input logic [REG_IDX_W-1:0] rs,
                               input logic [REG_IDX_W-1:0] rt, input logic [IMM_W-1:0] imm,
                               input logic [PRELOAD_ADDR_W-1:0] paddr,
                               input logic [XLEN-1:0] pdata, output step_outcome_type o);
      logic [XLEN-1:0] a;
      logic [XLEN-1:0] b;
      logic [SAW-1:0]  addr;
      logic [PC_W-1:0] pc_inc;
      logic [4:0]      sh;
      o.next_pc = arch_pc;
      o.status  = STATUS_DONE;
      o.written = 1'b0;
      o.index   = '0;
      o.value   = '0;
      if (kind == KIND_PRELOAD) begin
         shadow_store[SAW'(paddr % STORE_DEPTH)] = pdata;
      end else begin
         // immediate lands in R1 before the operands are read
         arch_regs[REG_IMM] = {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
         a      = arch_regs[rs];
         b      = arch_regs[rt];
         pc_inc = arch_pc + 1'b1;
         sh     = b[4:0];
         addr   = SAW'((a + b) % STORE_DEPTH);
         case (op)
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLL, OP_SRA, OP_SRL, OP_LW: begin
               o.written = 1'b1;
               o.index   = rd;
               o.next_pc = pc_inc;
               case (op)
                  OP_ADD:  o.value = a + b;
                  OP_SUB:  o.value = a - b;
                  OP_AND:  o.value = a & b;
                  OP_OR:   o.value = a | b;
                  OP_SLL:  o.value = a << sh;
                  OP_SRA:  o.value = $signed(a) >>> sh;
                  OP_SRL:  o.value = a >> sh;
                  default: o.value = shadow_store[addr];
               endcase
            end
            OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE: begin
               o.next_pc = branch_taken(op, a, b) ? arch_regs[rd][PC_W-1:0] : pc_inc;
            end
            OP_JAL: begin
               // link first, so a jump through R15 lands on pc+1
               arch_regs[REG_LINK] = XLEN'(pc_inc);
               o.next_pc = arch_regs[rd][PC_W-1:0];
               o.written = 1'b1;
               o.index   = REG_LINK;
               o.value   = XLEN'(pc_inc);
            end
            OP_SW: begin
               shadow_store[addr] = arch_regs[rd];
               o.next_pc = pc_inc;
            end
            OP_HALT: o.status = STATUS_HALTED;
            default: o.status = STATUS_UNSUPPORTED;
         endcase
         if (o.written) begin
            if (o.index == REG_ZERO) begin
               o.written = 1'b0;
               o.index   = '0;
               o.value   = '0;
            end else begin
               arch_regs[o.index] = o.value;
            end
         end
         arch_regs[REG_ZERO] = '0;
         arch_pc = o.next_pc;
      end
   endtask

   // Check result beats against the oldest expectation, then predict new request beats
   always @(posedge clock) begin : monitor
      step_outcome_type want;
      step_outcome_type predicted;
      if (reset) begin
         outcome_q.delete();
         arch_pc         = '0;
         op_seen         = '0;
         fail_count      = 0;
         exec_beats      = 0;
         preload_beats   = 0;
         checked_results = 0;
         for (int i = 0; i < NUM_REGS; i++)
            arch_regs[i] = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("result beat with nothing expected", XLEN'(rsp_next_pc), '0);
            end else begin
               want = outcome_q.pop_front();
               checked_results++;
               if (rsp_next_pc !== want.next_pc)
                  report_mismatch("next_pc", XLEN'(rsp_next_pc), XLEN'(want.next_pc));
               if (rsp_status !== want.status)
                  report_mismatch("status", XLEN'(rsp_status), XLEN'(want.status));
               if (rsp_dest_written !== want.written)
                  report_mismatch("dest_written", XLEN'(rsp_dest_written),
                                  XLEN'(want.written));
               if (rsp_dest_index !== want.index)
                  report_mismatch("dest_index", XLEN'(rsp_dest_index), XLEN'(want.index));
               if (rsp_dest_value !== want.value)
                  report_mismatch("dest_value", rsp_dest_value, want.value);
            end
         end
         if (req_valid && !req_stall) begin
            execute_step(req_kind, req_opcode, req_dest_reg, req_src_a_reg, req_src_b_reg,
                         req_immediate, req_preload_address, req_preload_data, predicted);
            outcome_q.push_back(predicted);
            if (req_kind == KIND_PRELOAD) begin
               preload_beats++;
            end else begin
               exec_beats++;
               op_seen[req_opcode] = 1'b1;
            end
         end
      end
   end

endmodule

// ----- sim/tb_risc_execute_unit_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the RISC execute unit: clock, reset, stimulus, back-pressure and verdict.
// Instantiates risc_execute_unit_top and rxu_exec_checker; depends on rxu_pkg.
module tb_risc_execute_unit_top;
   import rxu_pkg::*;

   localparam int unsigned DEPTH          = STORE_DEPTH_DEFAULT;
   localparam int unsigned RANDOM_BEATS   = 600;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned TAIL_CYCLES    = 8;
   // preloaded data store window: addresses -WINDOW_HALF .. WINDOW_HALF-1, wrapped
   localparam int unsigned WINDOW_HALF    = 32;

   // opcode range with no defined instruction (halt sits inside it)
   localparam logic [OPCODE_W-1:0] OP_FIRST_SPARE = 5'd16;
   localparam logic [OPCODE_W-1:0] OP_LAST_SPARE  = 5'd31;

   typedef struct packed {
      logic                      kind;
      logic [OPCODE_W-1:0]       opcode;
      logic [REG_IDX_W-1:0]      rd;
      logic [REG_IDX_W-1:0]      rs;
      logic [REG_IDX_W-1:0]      rt;
      logic [IMM_W-1:0]          imm;
      logic [PRELOAD_ADDR_W-1:0] paddr;
      logic [XLEN-1:0]           pdata;
   } req_beat_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_kind = 1'b0;
   logic        [OPCODE_W-1:0]       req_opcode = '0;
   logic        [REG_IDX_W-1:0]      req_dest_reg = '0;
   logic        [REG_IDX_W-1:0]      req_src_a_reg = '0;
   logic        [REG_IDX_W-1:0]      req_src_b_reg = '0;
   logic signed [IMM_W-1:0]          req_immediate = '0;
   logic        [PRELOAD_ADDR_W-1:0] req_preload_address = '0;
   logic signed [XLEN-1:0]           req_preload_data = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic        [PC_W-1:0]           rsp_next_pc;
   logic        [1:0]                rsp_status;
   logic                             rsp_dest_written;
   logic        [REG_IDX_W-1:0]      rsp_dest_index;
   logic signed [XLEN-1:0]           rsp_dest_value;

   int unsigned fail_count, pending_beats, exec_beats, preload_beats;
   int unsigned checked_results, opcodes_seen;
   int unsigned holds_wanted = 0;
   int unsigned holds_served = 0;

   always #5 clock = ~clock;

   risc_execute_unit_top #(.STORE_DEPTH(DEPTH)) dut (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_opcode, .req_dest_reg,
      .req_src_a_reg, .req_src_b_reg, .req_immediate, .req_preload_address,
      .req_preload_data, .rsp_valid, .rsp_stall, .rsp_next_pc, .rsp_status,
      .rsp_dest_written, .rsp_dest_index, .rsp_dest_value
   );

   rxu_exec_checker #(.STORE_DEPTH(DEPTH)) u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_opcode, .req_dest_reg,
      .req_src_a_reg, .req_src_b_reg, .req_immediate, .req_preload_address,
      .req_preload_data, .rsp_valid, .rsp_stall, .rsp_next_pc, .rsp_status,
      .rsp_dest_written, .rsp_dest_index, .rsp_dest_value, .fail_count, .pending_beats,
      .exec_beats, .preload_beats, .checked_results, .opcodes_seen
   );

   // Drive one request beat at the falling edge and hold it until taken
   task automatic send_beat(input req_beat_type beat);
      @(negedge clock);
      req_valid           <= 1'b1;
      req_kind            <= beat.kind;
      req_opcode          <= beat.opcode;
      req_dest_reg        <= beat.rd;
      req_src_a_reg       <= beat.rs;
      req_src_b_reg       <= beat.rt;
      req_immediate       <= beat.imm;
      req_preload_address <= beat.paddr;
      req_preload_data    <= beat.pdata;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic pause(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stop offering until every predicted result has been returned
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_beats != 0)
         @(posedge clock);
   endtask

   // Instruction beat; the unused preload fields carry noise
   function automatic req_beat_type exec_beat(input logic [OPCODE_W-1:0] op,
                                              input logic [REG_IDX_W-1:0] rd,
                                              input logic [REG_IDX_W-1:0] rs,
                                              input logic [REG_IDX_W-1:0] rt,
                                              input logic [IMM_W-1:0] imm);
      req_beat_type b;
      b.kind   = KIND_EXEC;
      b.opcode = op;
      b.rd     = rd;
      b.rs     = rs;
      b.rt     = rt;
      b.imm    = imm;
      b.paddr  = PRELOAD_ADDR_W'($urandom);
      b.pdata  = $urandom;
      return b;
   endfunction

   // Preload beat; the unused instruction fields carry noise
   function automatic req_beat_type preload_beat(input logic [PRELOAD_ADDR_W-1:0] addr,
                                                 input logic [XLEN-1:0] data);
      req_beat_type b;
      b.kind   = KIND_PRELOAD;
      b.opcode = OPCODE_W'($urandom);
      b.rd     = REG_IDX_W'($urandom);
      b.rs     = REG_IDX_W'($urandom);
      b.rt     = REG_IDX_W'($urandom);
      b.imm    = IMM_W'($urandom);
      b.paddr  = addr;
      b.pdata  = data;
      return b;
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      int unsigned  pick;
      b = exec_beat(OPCODE_W'($urandom), REG_IDX_W'($urandom), REG_IDX_W'($urandom),
                    REG_IDX_W'($urandom), IMM_W'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
         b.opcode = OPCODE_W'($urandom_range(OP_ADD, OP_SW));
      end else if (pick < 90) begin
         b.opcode = OP_HALT;
      end else begin
         b.opcode = OPCODE_W'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
         if (b.opcode == OP_HALT)
            b.opcode = OP_LAST_SPARE;
      end
      // lean on R1 so immediates feed the operands often
      if ($urandom_range(0, 3) == 0) b.rs = REG_IMM;
      if ($urandom_range(0, 3) == 0) b.rt = REG_IMM;
      if ($urandom_range(0, 6) == 0) begin
         case ($urandom_range(0, 3))
            0:       b.imm = 12'h800;
            1:       b.imm = 12'h7FF;
            2:       b.imm = 12'h000;
            default: b.imm = 12'hFFF;
         endcase
      end
      // loads address R1 plus R0, so they stay inside the preloaded window
      if (b.opcode == OP_LW) begin
         b.imm = IMM_W'($urandom_range(0, 2 * WINDOW_HALF - 1) - WINDOW_HALF);
         if ($urandom_range(0, 1) == 0) begin
            b.rs = REG_IMM;
            b.rt = REG_ZERO;
         end else begin
            b.rs = REG_ZERO;
            b.rt = REG_IMM;
         end
      end
      if ($urandom_range(0, 99) < 8) begin
         b.kind = KIND_PRELOAD;
         if ($urandom_range(0, 4) == 0)
            b.pdata = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return b;
   endfunction

   // Receiver back-pressure: segments of free flow, light, heavy and full stalling
   initial begin : receiver
      int unsigned mode, span, odds;
      forever begin
         if (holds_served < holds_wanted) begin
            holds_served++;
            mode = 3;
            span = $urandom_range(50, 80);
         end else begin
            mode = $urandom_range(0, 11);
            span = $urandom_range(4, 40);
            if (mode == 11) begin
               mode = 3;
               span = $urandom_range(40, 70);
            end else begin
               mode = mode % 3;
            end
         end
         odds = (mode == 0) ? 0 : (mode == 1) ? 25 : (mode == 2) ? 70 : 100;
         repeat (span) begin
            @(negedge clock);
            rsp_stall <= ($urandom_range(1, 100) <= odds);
         end
      end
   end

   // Ends the run if nothing moves on either channel for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t watchdog: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned sent, burst, next_drain;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill a window around address zero so no load can hit an unwritten word
      for (int a = 0; a < 2 * WINDOW_HALF; a++)
         send_beat(preload_beat(PRELOAD_ADDR_W'(a - WINDOW_HALF), XLEN'($urandom)));

      // Directed: operand extremes, every opcode, register zero, pc wrap
      send_beat(exec_beat(OP_ADD, 4'd2, REG_IMM, REG_ZERO, 12'h7FF));    // R2 = 2047
      send_beat(exec_beat(OP_SUB, 4'd3, REG_ZERO, REG_IMM, 12'h800));    // R3 = 2048
      send_beat(exec_beat(OP_SLL, 4'd4, REG_IMM, REG_IMM, 12'hFFF));     // R4 = min int
      send_beat(exec_beat(OP_SRA, 4'd5, 4'd4, REG_IMM, 12'h01F));        // full sign fill
      send_beat(exec_beat(OP_SRL, 4'd6, 4'd4, REG_IMM, 12'h01F));        // logical, gives 1
      send_beat(exec_beat(OP_SRA, 4'd7, 4'd4, REG_ZERO, 12'h000));       // shift by zero
      send_beat(exec_beat(OP_AND, 4'd8, 4'd5, REG_IMM, 12'h800));
      send_beat(exec_beat(OP_OR, 4'd9, 4'd2, REG_IMM, 12'h555));
      send_beat(exec_beat(OP_ADD, 4'd10, 4'd4, 4'd5, 12'h123));         // wraps to max int
      send_beat(exec_beat(OP_ADD, REG_ZERO, 4'd2, 4'd2, 12'h001));       // dropped write
      send_beat(exec_beat(OP_BEQ, 4'd2, 4'd5, 4'd5, 12'h000));           // taken
      send_beat(exec_beat(OP_BNE, 4'd3, REG_ZERO, REG_ZERO, 12'h000));   // not taken
      send_beat(exec_beat(OP_BLT, 4'd3, 4'd4, 4'd10, 12'h000));          // min < max
      send_beat(exec_beat(OP_BGT, 4'd2, 4'd10, 4'd4, 12'h000));
      send_beat(exec_beat(OP_BLE, 4'd6, 4'd5, 4'd5, 12'h000));           // equal operands
      send_beat(exec_beat(OP_BGE, 4'd3, 4'd4, 4'd5, 12'h000));           // not taken
      send_beat(exec_beat(OP_JAL, REG_LINK, REG_ZERO, REG_ZERO, 12'h000)); // target is pc+1
      send_beat(exec_beat(OP_SUB, 4'd12, REG_ZERO, REG_IMM, 12'h001));   // R12 = all ones
      send_beat(exec_beat(OP_JAL, 4'd12, REG_ZERO, REG_ZERO, 12'h000));  // pc to top
      send_beat(exec_beat(OP_OR, 4'd13, REG_ZERO, REG_ZERO, 12'h000));   // pc wraps
      send_beat(exec_beat(OP_SW, 4'd10, REG_IMM, REG_ZERO, 12'h064));
      send_beat(exec_beat(OP_LW, 4'd11, REG_IMM, REG_ZERO, 12'h064));
      send_beat(exec_beat(OP_LW, REG_ZERO, REG_IMM, REG_ZERO, 12'hFFF)); // address wraps
      send_beat(preload_beat(12'hFFF, 32'h8000_0000));
      send_beat(exec_beat(OP_LW, 4'd14, REG_IMM, REG_ZERO, 12'hFFF));
      send_beat(exec_beat(OP_HALT, 4'd3, 4'd3, 4'd3, 12'h7FF));
      send_beat(exec_beat(OP_FIRST_SPARE, 4'd4, REG_IMM, REG_IMM, 12'h800));
      send_beat(exec_beat(OP_LAST_SPARE, 4'd9, 4'd2, 4'd2, 12'hFFF));
      send_beat(preload_beat(12'h000, 32'h7FFF_FFFF));
      drain();

      // Random: bursts and gaps, one forced long hold-off, periodic drains
      holds_wanted = 1;
      sent = 0;
      next_drain = $urandom_range(100, 250);
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < RANDOM_BEATS; i++) begin
            send_beat(random_beat());
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            pause($urandom_range(1, 6));
         if (sent >= next_drain) begin
            drain();
            next_drain += $urandom_range(100, 250);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d instruction beats over %0d of 32 opcode values and %0d preloads;",
               exec_beats, opcodes_seen, preload_beats);
      $display("%0d result beats compared under random and long back-pressure.",
               checked_results);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
sv/rxu_pkg.sv
sv/rxu_regfile.sv
sv/rxu_alu.sv
sv/risc_execute_unit_top.sv
sv/rxu_checker.sv
sim/rxu_exec_checker.sv
sim/tb_risc_execute_unit_top.sv
